// ===== rtl/core/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int DEFAULT_STORE_SLOTS = 4096;

   // position arithmetic: header + 1 + length can pass the store end
   localparam int POS_W = 26;
   localparam int LEN_W = 24;
   localparam int SP_W  = 27;

   localparam logic [1:0]       TAG_USED    = 2'd1;
   localparam logic [1:0]       TAG_FREE    = 2'd2;
   localparam logic [POS_W-1:0] MERGE_LIMIT = 26'hfffffe;
   localparam logic [15:0]      COUNT_LIMIT = 16'd65534;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_CHECK = 2'd2;

   localparam logic [1:0] RSP_OK      = 2'd0;
   localparam logic [1:0] RSP_BAD     = 2'd1;
   localparam logic [1:0] RSP_NOSPACE = 2'd2;
   localparam logic [1:0] RSP_CORRUPT = 2'd3;

   typedef struct packed {
      logic [1:0]       tag;
      logic [LEN_W-1:0] len;
   } tag_word_type;

   typedef enum logic [1:0] {
      CTX_CAPF,
      CTX_CAPN,
      CTX_SRCH
   } ctx_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_FREE_D,
      S_CHK,
      S_CHK_D,
      S_CAP_D,
      S_CAPN_D,
      S_MRG_LOOP,
      S_MRG_D,
      S_MRG_RET,
      S_CAP_RES,
      S_SRCH,
      S_SRCH_D,
      S_CLAIM,
      S_CLM_D,
      S_SPL1,
      S_SPL2,
      S_POST,
      S_MOVE_D,
      S_DONE
   } state_type;

endpackage

// ===== rtl/core/ffba_tag_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_tag_mem
// Tag memory, one write and one registered read per cycle, with
// write-to-read forwarding, range guard and the reset header of slot 0.
// ----------------------------------------------------------------------------
module ffba_tag_mem
   import ffba_pkg::*;
#(
   parameter int STORE_SLOTS = DEFAULT_STORE_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [POS_W-1:0]   rd_addr,
   output tag_word_type       rd_word,
   input  logic               wr_en,
   input  logic [POS_W-1:0]   wr_addr,
   input  tag_word_type       wr_word
);
   localparam int ADDR_W = $clog2(STORE_SLOTS);
   localparam logic [POS_W-1:0] STORE_POS = POS_W'(STORE_SLOTS);
   localparam tag_word_type RESET_WORD = '{tag: TAG_FREE, len: LEN_W'(STORE_SLOTS - 1)};

   tag_word_type mem [STORE_SLOTS];
   tag_word_type raw_ff;
   tag_word_type fwd_word_ff;
   logic         fwd_ff, fwd_in;
   logic         oob_ff, oob_in;
   logic         init_hit_ff, init_hit_in;
   logic         init0_ff, init0_in;
   logic         wr_ok;

   assign wr_ok       = wr_en && (wr_addr < STORE_POS);
   assign fwd_in      = wr_ok && (wr_addr == rd_addr);
   assign oob_in      = rd_addr >= STORE_POS;
   assign init_hit_in = init0_ff && (rd_addr == '0);
   assign init0_in    = init0_ff && !(wr_ok && wr_addr == '0);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr[ADDR_W-1:0]] <= wr_word;
      end
      raw_ff      <= mem[rd_addr[ADDR_W-1:0]];
      fwd_word_ff <= wr_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff      <= 1'b0;
         oob_ff      <= 1'b0;
         init_hit_ff <= 1'b0;
         init0_ff    <= 1'b1;
      end else begin
         fwd_ff      <= fwd_in;
         oob_ff      <= oob_in;
         init_hit_ff <= init_hit_in;
         init0_ff    <= init0_in;
      end
   end

   always_comb begin
      if (oob_ff) begin
         rd_word = '0;
      end else if (fwd_ff) begin
         rd_word = fwd_word_ff;
      end else if (init_hit_ff) begin
         rd_word = RESET_WORD;
      end else begin
         rd_word = raw_ff;
      end
   end

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit slot allocator with in-place growth and coalescing of free runs.
// ----------------------------------------------------------------------------
// One request item is taken at a time and answered by exactly one result item.
// The run headers live in a tag memory with one write port and one registered
// read port, and a sequencer walks them one header at a time (address, then
// data). A free reads and rewrites one header, a chain check walks the chain
// of headers, and an allocate reads the headers visited while growing,
// merging and searching, then writes the split and releases a moved run;
// so the cost follows fragmentation. A new request is taken while
// the last result still waits on the output register. After reset slot 0 reads
// as one free run over the whole store; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int STORE_SLOTS = DEFAULT_STORE_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // old_handle[13:0], link_count[29:14], zero pad
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // handle[12:0], status[14:13], moved[15]
);
   localparam int ADDR_W = $clog2(STORE_SLOTS);
   localparam logic [POS_W-1:0] STORE_POS = POS_W'(STORE_SLOTS);
   localparam logic [POS_W-1:0] ONE = POS_W'(1);

   state_type state_ff, state_in;

   // request
   logic [1:0]         func_ff, func_in;
   logic signed [13:0] old_ff, old_in;
   logic [15:0]        n_ff, n_in;

   // walk registers
   logic [POS_W-1:0]   pos_ff, pos_in;      // check position / merge probe
   logic [POS_W-1:0]   slot_ff, slot_in;    // search position
   logic [POS_W-1:0]   mslot_ff, mslot_in;  // run being merged
   logic [LEN_W-1:0]   mlen_ff, mlen_in;
   logic [POS_W-1:0]   cslot_ff, cslot_in;  // run being claimed
   logic [LEN_W-1:0]   clen_ff, clen_in;
   logic [POS_W-1:0]   upto_ff, upto_in;
   logic signed [SP_W-1:0] sp_ff, sp_in;
   logic [POS_W-1:0]   rdpos_ff, rdpos_in;
   ctx_type            mctx_ff, mctx_in;
   logic               found_ff, found_in;
   logic               nohint_ff, nohint_in;
   logic               cold_ff, cold_in;    // claim on the caller's run
   logic               setlast_ff, setlast_in;

   // allocator state
   logic [ADDR_W-1:0]  hint_ff, hint_in;
   logic [ADDR_W-1:0]  last_ff, last_in;

   // result
   logic [1:0]         status_ff, status_in;
   logic [12:0]        handle_ff, handle_in;
   logic               moved_ff, moved_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   // tag memory
   tag_word_type       rd_word, wr_word;
   logic [POS_W-1:0]   rd_addr, wr_addr;
   logic               wr_en;

   ffba_tag_mem #(
      .STORE_SLOTS(STORE_SLOTS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_word (wr_word)
   );

   // ---- shared decode -------------------------------------------------------
   logic [POS_W-1:0] last_pos, hint_pos, d_end, old_val, old_pos, cnh, nh2, msum;
   logic             d_ok, d_used, d_last;
   logic             old_neg, old_none, old_big, has_old, free_bad, alloc_bad;
   logic             ret_last, spm_fit, sp_fit;
   logic signed [SP_W-1:0] n_sp, spm;

   assign last_pos = POS_W'(last_ff);
   assign hint_pos = POS_W'(hint_ff);
   // header just read: valid tag and run inside the store
   assign d_end  = rdpos_ff + ONE + POS_W'(rd_word.len);
   assign d_ok   = (rd_word.tag == TAG_USED || rd_word.tag == TAG_FREE) && (d_end <= STORE_POS);
   assign d_used = rd_word.tag == TAG_USED;
   assign d_last = rdpos_ff == last_pos;

   assign old_neg   = old_ff[13];
   assign old_none  = old_ff == -14'sd1;
   assign old_val   = POS_W'(old_ff[12:0]);
   assign old_pos   = old_val - ONE;
   assign old_big   = !old_neg && (old_val > STORE_POS);
   assign has_old   = !old_neg && (old_ff != 14'sd0);
   assign free_bad  = old_neg || (old_ff == 14'sd0) || old_big;
   assign alloc_bad = (old_ff == 14'sd0) || (old_neg && !old_none) || old_big ||
                      (n_ff == 16'd0) || (n_ff >= COUNT_LIMIT);

   assign n_sp     = $signed(SP_W'(n_ff));
   assign ret_last = mslot_ff == last_pos;
   assign spm      = $signed(SP_W'(mlen_ff)) - $signed(SP_W'(nohint_ff || ret_last));
   assign spm_fit  = spm >= n_sp;
   assign sp_fit   = sp_ff >= n_sp;

   assign msum = POS_W'(mlen_ff) + ONE + POS_W'(rd_word.len);
   assign cnh  = cslot_ff + ONE + POS_W'(clen_ff);
   assign nh2  = cslot_ff + ONE + POS_W'(n_ff);

   // ---- next state ---------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_START;
         end
         S_START: begin
            case (func_ff)
               FUNC_CHECK: state_in = S_CHK;
               FUNC_FREE:  state_in = free_bad ? S_DONE : S_FREE_D;
               FUNC_ALLOC: begin
                  if (alloc_bad) state_in = S_DONE;
                  else if (has_old) state_in = S_CAP_D;
                  else state_in = S_SRCH;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_FREE_D: state_in = S_DONE;
         S_CHK: state_in = (pos_ff >= STORE_POS) ? S_DONE : S_CHK_D;
         S_CHK_D: state_in = d_ok ? S_CHK : S_DONE;
         S_CAP_D: begin
            if (!d_ok) state_in = S_DONE;
            else if (!d_used) state_in = d_last ? S_MRG_RET : S_MRG_LOOP;
            else if (d_end == last_pos) state_in = S_CAP_RES;
            else if (d_end > last_pos) state_in = S_DONE;
            else state_in = S_CAPN_D;
         end
         S_CAPN_D: begin
            if (!d_ok) state_in = S_DONE;
            else if (d_used) state_in = S_CAP_RES;
            else state_in = d_last ? S_MRG_RET : S_MRG_LOOP;
         end
         S_MRG_LOOP: state_in = (pos_ff <= last_pos) ? S_MRG_D : S_MRG_RET;
         S_MRG_D: begin
            if (!d_ok) state_in = S_DONE;
            else if (d_used || msum >= MERGE_LIMIT) state_in = S_MRG_RET;
            else state_in = S_MRG_LOOP;
         end
         S_MRG_RET: begin
            if (mctx_ff == CTX_SRCH) state_in = spm_fit ? S_CLAIM : S_SRCH;
            else state_in = S_CAP_RES;
         end
         S_CAP_RES: state_in = sp_fit ? S_CLAIM : S_SRCH;
         S_SRCH: state_in = (slot_ff <= last_pos) ? S_SRCH_D : S_DONE;
         S_SRCH_D: begin
            if (!d_ok) state_in = S_DONE;
            else if (d_used || rd_word.len == '0) state_in = S_SRCH;
            else state_in = d_last ? S_MRG_RET : S_MRG_LOOP;
         end
         S_CLAIM: begin
            if (cslot_ff == last_pos) state_in = S_SPL1;
            else if (LEN_W'(n_ff) > clen_ff) begin
               state_in = (cnh == last_pos) ? S_SPL1 : S_CLM_D;
            end else if (LEN_W'(n_ff) < clen_ff) state_in = S_SPL1;
            else state_in = S_POST;
         end
         S_CLM_D: state_in = (nh2 < cnh + ONE + POS_W'(rd_word.len)) ? S_SPL1 : S_POST;
         S_SPL1: state_in = S_SPL2;
         S_SPL2: state_in = S_POST;
         S_POST: begin
            if (!cold_ff && has_old && slot_ff != old_pos) state_in = S_MOVE_D;
            else state_in = S_DONE;
         end
         S_MOVE_D: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---- datapath and outputs ----------------------------------------------
   always_comb begin
      func_in    = func_ff;
      old_in     = old_ff;
      n_in       = n_ff;
      pos_in     = pos_ff;
      slot_in    = slot_ff;
      mslot_in   = mslot_ff;
      mlen_in    = mlen_ff;
      cslot_in   = cslot_ff;
      clen_in    = clen_ff;
      upto_in    = upto_ff;
      sp_in      = sp_ff;
      mctx_in    = mctx_ff;
      found_in   = found_ff;
      nohint_in  = nohint_ff;
      cold_in    = cold_ff;
      setlast_in = setlast_ff;
      hint_in    = hint_ff;
      last_in    = last_ff;
      status_in  = status_ff;
      handle_in  = handle_ff;
      moved_in   = moved_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr    = rdpos_ff;
      wr_en      = 1'b0;
      wr_addr    = cslot_ff;
      wr_word    = '{tag: TAG_USED, len: LEN_W'(n_ff)};

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               old_in  = $signed(req_tdata[13:0]);
               n_in    = req_tdata[29:14];
            end
         end
         S_START: begin
            status_in = RSP_OK;
            handle_in = '0;
            moved_in  = 1'b0;
            pos_in    = '0;
            rd_addr   = old_pos;
            slot_in   = hint_pos;
            found_in  = 1'b0;
            case (func_ff)
               FUNC_CHECK: ;
               FUNC_FREE:  if (free_bad) status_in = RSP_BAD;
               FUNC_ALLOC: if (alloc_bad) status_in = RSP_BAD;
               default:    status_in = RSP_BAD;
            endcase
         end
         S_FREE_D: begin
            wr_en   = 1'b1;
            wr_addr = rdpos_ff;
            wr_word = '{tag: TAG_FREE, len: rd_word.len};
            if (hint_pos > rdpos_ff && rd_word.len != '0) hint_in = rdpos_ff[ADDR_W-1:0];
         end
         S_CHK: rd_addr = pos_ff;
         S_CHK_D: begin
            if (!d_ok) status_in = RSP_CORRUPT;
            pos_in = d_end;
         end
         S_CAP_D, S_CAPN_D, S_SRCH_D: begin
            if (state_ff == S_CAP_D) clen_in = rd_word.len;
            rd_addr = d_end;
            if (!d_ok) begin
               status_in = RSP_CORRUPT;
            end else if (d_used) begin
               // used run: caller's run, neighbour, or skipped in the search
               if (state_ff == S_CAP_D) begin
                  sp_in = $signed(SP_W'(rd_word.len));
                  if (d_end > last_pos) status_in = RSP_CORRUPT;
               end else if (state_ff == S_CAPN_D) begin
                  sp_in = $signed(SP_W'(clen_ff));
               end else begin
                  slot_in = d_end;
               end
            end else if (state_ff == S_SRCH_D && rd_word.len == '0) begin
               slot_in = slot_ff + ONE;
            end else begin
               // free run: start coalescing it
               mslot_in  = rdpos_ff;
               mlen_in   = rd_word.len;
               nohint_in = d_last;
               pos_in    = d_end;
               case (state_ff)
                  S_CAP_D:  mctx_in = CTX_CAPF;
                  S_CAPN_D: mctx_in = CTX_CAPN;
                  default:  mctx_in = CTX_SRCH;
               endcase
            end
         end
         S_MRG_LOOP: rd_addr = pos_ff;
         S_MRG_D: begin
            if (!d_ok) begin
               status_in = RSP_CORRUPT;
            end else if (!d_used && msum < MERGE_LIMIT) begin
               if (d_last) last_in = mslot_ff[ADDR_W-1:0];
               mlen_in = msum[LEN_W-1:0];
               pos_in  = mslot_ff + ONE + msum;
               wr_en   = 1'b1;
               wr_addr = mslot_ff;
               wr_word = '{tag: TAG_FREE, len: msum[LEN_W-1:0]};
            end
         end
         S_MRG_RET: begin
            if (!nohint_ff && hint_pos > mslot_ff && mlen_ff != '0) begin
               hint_in = mslot_ff[ADDR_W-1:0];
            end
            case (mctx_ff)
               CTX_CAPF: begin
                  sp_in   = spm;
                  clen_in = mlen_ff;
               end
               CTX_CAPN: sp_in = $signed(SP_W'(clen_ff)) + SP_W'(1) + spm;
               default: begin
                  cslot_in = mslot_ff;
                  clen_in  = mlen_ff;
                  cold_in  = 1'b0;
                  found_in = !spm_fit;
                  if (!spm_fit) slot_in = slot_ff + POS_W'(spm) + ONE;
               end
            endcase
         end
         S_CAP_RES: begin
            cslot_in = old_pos;
            cold_in  = 1'b1;
            slot_in  = hint_pos;
            found_in = 1'b0;
         end
         S_SRCH: begin
            rd_addr = slot_ff;
            if (slot_ff <= last_pos) begin
               if (!found_ff) hint_in = slot_ff[ADDR_W-1:0];
            end else begin
               status_in = RSP_NOSPACE;
            end
         end
         S_CLAIM: begin
            rd_addr    = cnh;
            upto_in    = STORE_POS;
            setlast_in = 1'b1;
            if (cslot_ff != last_pos) begin
               if (LEN_W'(n_ff) > clen_ff) begin
                  if (cnh != last_pos) setlast_in = 1'b0;
               end else if (LEN_W'(n_ff) < clen_ff) begin
                  upto_in    = cnh;
                  setlast_in = 1'b0;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         S_CLM_D: begin
            upto_in    = cnh + ONE + POS_W'(rd_word.len);
            setlast_in = 1'b0;
            if (!(nh2 < upto_in)) begin
               // next free run taken whole
               wr_en = 1'b1;
               if (hint_pos == cnh) hint_in = upto_in[ADDR_W-1:0];
            end
         end
         S_SPL1: begin
            wr_en   = 1'b1;
            wr_addr = nh2;
            wr_word = '{tag: TAG_FREE, len: LEN_W'(upto_ff - nh2 - ONE)};
         end
         S_SPL2: begin
            wr_en = 1'b1;
            if (hint_pos > cslot_ff && hint_pos < upto_ff) hint_in = nh2[ADDR_W-1:0];
            if (setlast_ff) last_in = nh2[ADDR_W-1:0];
         end
         S_POST: begin
            rd_addr = old_pos;
            if (cold_ff) handle_in = old_ff[12:0];
            else handle_in = 13'(slot_ff + ONE);
         end
         S_MOVE_D: begin
            // release the caller's old run after relocation
            wr_en    = 1'b1;
            wr_addr  = rdpos_ff;
            wr_word  = '{tag: TAG_FREE, len: rd_word.len};
            if (hint_pos > rdpos_ff) hint_in = rdpos_ff[ADDR_W-1:0];
            moved_in = 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (status_ff == RSP_OK) rsp_data_in = {moved_ff, status_ff, handle_ff};
               else rsp_data_in = {1'b0, status_ff, 13'd0};
            end
         end
         default: ;
      endcase
   end

   assign rdpos_in   = rd_addr;
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hint_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      old_ff      <= old_in;
      n_ff        <= n_in;
      pos_ff      <= pos_in;
      slot_ff     <= slot_in;
      mslot_ff    <= mslot_in;
      mlen_ff     <= mlen_in;
      cslot_ff    <= cslot_in;
      clen_ff     <= clen_in;
      upto_ff     <= upto_in;
      sp_ff       <= sp_in;
      rdpos_ff    <= rdpos_in;
      mctx_ff     <= mctx_in;
      found_ff    <= found_in;
      nohint_ff   <= nohint_in;
      cold_ff     <= cold_in;
      setlast_ff  <= setlast_in;
      status_ff   <= status_in;
      handle_ff   <= handle_in;
      moved_ff    <= moved_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
